// ----- hdl/bc_pkg.sv -----
// ----------------------------------------------------------------------------
// bc_pkg
// Shared types and constants of the barometer compensation pipeline.
// ----------------------------------------------------------------------------
package bc_pkg;

  // Configuration register indexes (byte address = 4 * index).
  localparam logic [2:0] REG_SENS      = 3'd0;
  localparam logic [2:0] REG_OFF       = 3'd1;
  localparam logic [2:0] REG_SENS_TEMP = 3'd2;
  localparam logic [2:0] REG_OFF_TEMP  = 3'd3;
  localparam logic [2:0] REG_REF_TEMP  = 3'd4;
  localparam logic [2:0] REG_SLOPE     = 3'd5;

  // Reference temperature of 20.00 C and the distance from it to -15.00 C.
  localparam logic [10:0] TEMP_REF = 11'd2000;
  localparam logic [11:0] LOW_SPAN = 12'd3500;

  // Output saturation limits.
  localparam logic signed [14:0] TEMP_MIN  = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX  = 15'sd8500;
  localparam logic [16:0]        PRESS_MIN = 17'd1000;
  localparam logic [16:0]        PRESS_MAX = 17'd120000;

  // Division by 100 as a multiply by ceil(2^24 / 100) and a shift by 24.
  // Exact for every value up to the pressure ceiling.
  localparam logic [17:0] DIV100_K = 18'd167773;

  // Handoff from the front stages: first-order results.
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [18:0] tq;    // (dT * C6) >> 23, temperature minus 20.00 C
    logic [16:0]        t2;    // (dT * dT) >> 31
    logic signed [35:0] off;
    logic signed [34:0] sens;
  } bc_front_t;

  // Handoff from the correction stages.
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [20:0] temp;
    logic signed [41:0] off;
    logic signed [39:0] sens;
  } bc_corr_t;

  // Handoff from the pressure stages: unsaturated results.
  typedef struct packed {
    logic signed [20:0] temp;
    logic signed [28:0] press;
  } bc_press_t;

  // Final result beat.
  typedef struct packed {
    logic [10:0]        press_whole;
    logic signed [7:0]  temp_whole;
    logic [16:0]        press_hundredths;
    logic signed [14:0] temp_hundredths;
  } bc_result_t;

endpackage

// ----- hdl/barometer_compensation.sv -----
// ----------------------------------------------------------------------------
// barometer_compensation
// Second-order temperature compensation of a barometric pressure sensor.
// ----------------------------------------------------------------------------
// One input beat carries a raw 24-bit pressure and a raw 24-bit temperature
// conversion; one output beat returns the compensated temperature (0.01 C,
// saturated to -40.00..85.00) and pressure (0.01 mbar, saturated to
// 10.00..1200.00), each also in whole units truncated toward zero. The six
// calibration words are written over the APB port at byte addresses 0, 4,
// ..., 20 and read back there. The datapath is an eleven-stage pipeline, and
// a new beat is accepted every cycle while the output is not stalled. Each
// stage holds its data while the next one is full and stalled, so
// backpressure on the output fills bubbles before s_tready drops.
// Calibration words are read live by the pipeline and are meant to be
// changed only while no beat is in flight.
// ----------------------------------------------------------------------------
module barometer_compensation
  import bc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // [14:0] temp_hundredths, [31:15] press_hundredths, [39:32] temp_whole,
  // [50:40] press_whole, [55:51] zero
  output logic [55:0] m_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] sens_coeff;
  logic [15:0] off_coeff;
  logic [15:0] sens_temp_coeff;
  logic [15:0] off_temp_coeff;
  logic [15:0] ref_temp_coeff;
  logic [15:0] temp_slope_coeff;
  logic        cfg_write;
  logic [2:0]  reg_index;

  logic        front_valid;
  logic        front_ready;
  bc_front_t   front_data;
  logic        corr_valid;
  logic        corr_ready;
  bc_corr_t    corr_data;
  logic        press_valid;
  logic        press_ready;
  bc_press_t   press_data;
  bc_result_t  result;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_coeff       <= 16'd0;
      off_coeff        <= 16'd0;
      sens_temp_coeff  <= 16'd0;
      off_temp_coeff   <= 16'd0;
      ref_temp_coeff   <= 16'd0;
      temp_slope_coeff <= 16'd0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_SENS:      sens_coeff       <= pwdata[15:0];
        REG_OFF:       off_coeff        <= pwdata[15:0];
        REG_SENS_TEMP: sens_temp_coeff  <= pwdata[15:0];
        REG_OFF_TEMP:  off_temp_coeff   <= pwdata[15:0];
        REG_REF_TEMP:  ref_temp_coeff   <= pwdata[15:0];
        REG_SLOPE:     temp_slope_coeff <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_SENS:      prdata = {16'd0, sens_coeff};
      REG_OFF:       prdata = {16'd0, off_coeff};
      REG_SENS_TEMP: prdata = {16'd0, sens_temp_coeff};
      REG_OFF_TEMP:  prdata = {16'd0, off_temp_coeff};
      REG_REF_TEMP:  prdata = {16'd0, ref_temp_coeff};
      REG_SLOPE:     prdata = {16'd0, temp_slope_coeff};
      default:       prdata = 32'd0;
    endcase
  end

  bc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .raw_pressure     (s_tdata[23:0]),
    .raw_temperature  (s_tdata[47:24]),
    .sens_coeff       (sens_coeff),
    .off_coeff        (off_coeff),
    .sens_temp_coeff  (sens_temp_coeff),
    .off_temp_coeff   (off_temp_coeff),
    .ref_temp_coeff   (ref_temp_coeff),
    .temp_slope_coeff (temp_slope_coeff),
    .out_valid        (front_valid),
    .out_ready        (front_ready),
    .out_data         (front_data)
  );

  bc_correct u_correct (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (corr_valid),
    .out_ready (corr_ready),
    .out_data  (corr_data)
  );

  bc_press u_press (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (corr_valid),
    .in_ready  (corr_ready),
    .in_data   (corr_data),
    .out_valid (press_valid),
    .out_ready (press_ready),
    .out_data  (press_data)
  );

  bc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (press_valid),
    .in_ready  (press_ready),
    .in_data   (press_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (result)
  );

  assign m_tdata = {5'd0, result};

endmodule

// ----- hdl/bc_front.sv -----
// ----------------------------------------------------------------------------
// bc_front
// Two stages: temperature difference dT, then the first-order products for
// temperature, offset and sensitivity, plus the dT squared term.
// ----------------------------------------------------------------------------
module bc_front
  import bc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [23:0]     raw_pressure,
  input  logic [23:0]     raw_temperature,
  input  logic [15:0]     sens_coeff,
  input  logic [15:0]     off_coeff,
  input  logic [15:0]     sens_temp_coeff,
  input  logic [15:0]     off_temp_coeff,
  input  logic [15:0]     ref_temp_coeff,
  input  logic [15:0]     temp_slope_coeff,
  output logic            out_valid,
  input  logic            out_ready,
  output bc_front_t       out_data
);

  logic               v1;
  logic               en1;
  logic               en2;
  logic [23:0]        d1_s1;
  logic signed [24:0] dt_s1;
  logic signed [24:0] dt_next;

  logic signed [41:0] tq_prod;
  logic signed [41:0] off_prod;
  logic signed [41:0] sens_prod;
  logic signed [49:0] sq_prod;
  bc_front_t          front_next;

  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, ref_temp_coeff, 8'h00});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_s1 <= raw_pressure;
      dt_s1 <= dt_next;
    end
  end

  assign tq_prod   = dt_s1 * $signed({1'b0, temp_slope_coeff});
  assign off_prod  = dt_s1 * $signed({1'b0, off_temp_coeff});
  assign sens_prod = dt_s1 * $signed({1'b0, sens_temp_coeff});
  assign sq_prod   = dt_s1 * dt_s1;

  // Taking the upper bits of a signed product is a floor shift.
  always_comb begin
    front_next.d1   = d1_s1;
    front_next.tq   = tq_prod[41:23];
    front_next.t2   = sq_prod[47:31];
    front_next.off  = $signed({3'b000, off_coeff, 17'd0}) + $signed(off_prod[41:6]);
    front_next.sens = $signed({3'b000, sens_coeff, 16'd0}) + $signed(sens_prod[41:7]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      out_data <= front_next;
    end
  end

endmodule

// ----- hdl/bc_correct.sv -----
// ----------------------------------------------------------------------------
// bc_correct
// Three stages of second-order correction: squares of the temperature
// distances, the offset and sensitivity terms, and their application.
// ----------------------------------------------------------------------------
module bc_correct
  import bc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  bc_front_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output bc_corr_t   out_data
);

  // Stage 3: squares.
  logic               v3;
  logic               en3;
  logic signed [19:0] b_dist;
  logic signed [37:0] aa_prod;
  logic signed [39:0] bb_prod;
  logic [23:0]        d1_s3;
  logic signed [18:0] tq_s3;
  logic [16:0]        t2_s3;
  logic signed [35:0] off_s3;
  logic signed [34:0] sens_s3;
  logic [34:0]        aa_s3;
  logic [34:0]        bb_s3;
  logic               low_s3;
  logic               vlow_s3;

  // Stage 4: correction terms.
  logic               v4;
  logic               en4;
  logic [40:0]        aa61;
  logic [38:0]        bb15;
  logic [39:0]        off2_next;
  logic [38:0]        sens2_next;
  logic signed [20:0] temp_next;
  logic [23:0]        d1_s4;
  logic signed [20:0] temp_s4;
  logic signed [35:0] off_s4;
  logic signed [34:0] sens_s4;
  logic [39:0]        off2_s4;
  logic [38:0]        sens2_s4;
  logic               low_s4;

  // Stage 5: apply.
  logic               en5;
  bc_corr_t           corr_next;

  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign in_ready = en3;

  // b_dist is negative exactly when the temperature is below -15.00 C.
  assign b_dist  = $signed({in_data.tq[18], in_data.tq}) + $signed({8'd0, LOW_SPAN});
  assign aa_prod = $signed(in_data.tq) * $signed(in_data.tq);
  assign bb_prod = b_dist * b_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      d1_s3   <= in_data.d1;
      tq_s3   <= in_data.tq;
      t2_s3   <= in_data.t2;
      off_s3  <= in_data.off;
      sens_s3 <= in_data.sens;
      aa_s3   <= aa_prod[34:0];
      bb_s3   <= bb_prod[34:0];
      low_s3  <= in_data.tq[18];
      vlow_s3 <= b_dist[19];
    end
  end

  assign aa61 = {aa_s3, 6'd0} - {4'd0, aa_s3, 2'd0} + {6'd0, aa_s3};
  assign bb15 = {bb_s3, 4'd0} - {4'd0, bb_s3};

  always_comb begin
    off2_next  = {3'd0, aa61[40:4]} + (vlow_s3 ? {1'b0, bb15} : 40'd0);
    sens2_next = {3'd0, aa_s3, 1'b0} + (vlow_s3 ? {1'b0, bb_s3, 3'd0} : 39'd0);
    temp_next  = $signed({{2{tq_s3[18]}}, tq_s3}) + $signed({10'd0, TEMP_REF})
               - $signed({4'd0, (low_s3 ? t2_s3 : 17'd0)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      d1_s4    <= d1_s3;
      temp_s4  <= temp_next;
      off_s4   <= off_s3;
      sens_s4  <= sens_s3;
      off2_s4  <= off2_next;
      sens2_s4 <= sens2_next;
      low_s4   <= low_s3;
    end
  end

  always_comb begin
    corr_next.d1   = d1_s4;
    corr_next.temp = temp_s4;
    corr_next.off  = $signed({{6{off_s4[35]}}, off_s4})
                   - $signed({2'b00, (low_s4 ? off2_s4 : 40'd0)});
    corr_next.sens = $signed({{5{sens_s4[34]}}, sens_s4})
                   - $signed({1'b0, (low_s4 ? sens2_s4 : 39'd0)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en5) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_data <= corr_next;
    end
  end

endmodule

// ----- hdl/bc_press.sv -----
// ----------------------------------------------------------------------------
// bc_press
// Three stages of pressure: the raw pressure times sensitivity as two
// partial products, their sum shifted by 21, then the offset and shift by 15.
// ----------------------------------------------------------------------------
module bc_press
  import bc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  bc_corr_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output bc_press_t  out_data
);

  logic               v6;
  logic               v7;
  logic               en6;
  logic               en7;
  logic               en8;

  logic [43:0]        lo_prod;
  logic signed [44:0] hi_prod;
  logic [43:0]        lo_s6;
  logic signed [44:0] hi_s6;
  logic signed [20:0] temp_s6;
  logic signed [41:0] off_s6;

  logic [63:0]        full_prod;
  logic signed [42:0] x_s7;
  logic signed [20:0] temp_s7;
  logic signed [41:0] off_s7;

  logic signed [43:0] y_diff;
  bc_press_t          press_next;

  assign en8      = !out_valid || out_ready;
  assign en7      = !v7 || en8;
  assign en6      = !v6 || en7;
  assign in_ready = en6;

  // Sensitivity split into a low unsigned half and a high signed half.
  assign lo_prod = in_data.d1 * in_data.sens[19:0];
  assign hi_prod = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[39:20]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en6) begin
      v6 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      lo_s6   <= lo_prod;
      hi_s6   <= hi_prod;
      temp_s6 <= in_data.temp;
      off_s6  <= in_data.off;
    end
  end

  // The true product fits in 64 bits, so modular addition is exact.
  assign full_prod = {hi_s6[43:0], 20'd0} + {20'd0, lo_s6};

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en7) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      x_s7    <= $signed(full_prod[63:21]);
      temp_s7 <= temp_s6;
      off_s7  <= off_s6;
    end
  end

  assign y_diff = $signed({x_s7[42], x_s7}) - $signed({{2{off_s7[41]}}, off_s7});

  always_comb begin
    press_next.temp  = temp_s7;
    press_next.press = y_diff[43:15];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en8) begin
      out_valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en8) begin
      out_data <= press_next;
    end
  end

endmodule

// ----- hdl/bc_out.sv -----
// ----------------------------------------------------------------------------
// bc_out
// Three stages of output: saturation, division by 100 through a reciprocal
// multiply, and the output register that holds a beat until it is taken.
// ----------------------------------------------------------------------------
module bc_out
  import bc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  bc_press_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output bc_result_t out_data
);

  logic               v9;
  logic               v10;
  logic               en9;
  logic               en10;
  logic               en11;

  logic signed [14:0] tc_next;
  logic [16:0]        pc_next;
  logic signed [14:0] tc_s9;
  logic [16:0]        pc_s9;

  logic               tneg;
  logic [14:0]        tabs_full;
  logic [31:0]        tq_prod;
  logic [34:0]        pq_prod;
  logic signed [14:0] tc_s10;
  logic [16:0]        pc_s10;
  logic [7:0]         tq_s10;
  logic [10:0]        pq_s10;
  logic               tneg_s10;

  bc_result_t         result_next;

  assign en11     = !out_valid || out_ready;
  assign en10     = !v10 || en11;
  assign en9      = !v9 || en10;
  assign in_ready = en9;

  always_comb begin
    priority if (in_data.temp < TEMP_MIN) begin
      tc_next = TEMP_MIN;
    end else if (in_data.temp > TEMP_MAX) begin
      tc_next = TEMP_MAX;
    end else begin
      tc_next = in_data.temp[14:0];
    end
    priority if (in_data.press < $signed({12'd0, PRESS_MIN})) begin
      pc_next = PRESS_MIN;
    end else if (in_data.press > $signed({12'd0, PRESS_MAX})) begin
      pc_next = PRESS_MAX;
    end else begin
      pc_next = in_data.press[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en9) begin
      v9 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en9) begin
      tc_s9 <= tc_next;
      pc_s9 <= pc_next;
    end
  end

  // Temperature divides on its magnitude so the quotient truncates toward zero.
  assign tneg      = tc_s9[14];
  assign tabs_full = tneg ? (15'd0 - tc_s9) : tc_s9;
  assign tq_prod   = tabs_full[13:0] * DIV100_K;
  assign pq_prod   = pc_s9 * DIV100_K;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en10) begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en10) begin
      tc_s10   <= tc_s9;
      pc_s10   <= pc_s9;
      tq_s10   <= tq_prod[31:24];
      pq_s10   <= pq_prod[34:24];
      tneg_s10 <= tneg;
    end
  end

  always_comb begin
    result_next.temp_hundredths  = tc_s10;
    result_next.press_hundredths = pc_s10;
    result_next.temp_whole       = tneg_s10 ? (8'd0 - tq_s10) : tq_s10;
    result_next.press_whole      = pq_s10;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en11) begin
      out_valid <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en11) begin
      out_data <= result_next;
    end
  end

endmodule

// ----- tb/barometer_compensation_tb.sv -----
// ----------------------------------------------------------------------------
// barometer_compensation_tb
// Self-checking bench for the barometer compensation pipeline.
// ----------------------------------------------------------------------------
// Raw pressure and temperature conversions are streamed into the block under
// several calibration sets, written and read back over APB while the pipeline
// is empty. Each accepted input beat is run through a local integer model of
// the second-order compensation, and each output beat is compared field by
// field with the oldest predicted reading. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module barometer_compensation_tb;
  import bc_pkg::*;

  localparam longint REF_HUNDREDTHS = 2000;
  localparam longint LOW_HUNDREDTHS = -1500;
  localparam longint TEMP_FLOOR     = -4000;
  localparam longint TEMP_CEIL      = 8500;
  localparam longint PRESS_FLOOR    = 1000;
  localparam longint PRESS_CEIL     = 120000;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [15:0] cal_words [0:5];
  logic [47:0] pending_samples [$];
  bc_result_t  expected_readings [$];
  bc_result_t  want_reading;
  bc_result_t  got_reading;
  int          mismatches = 0;
  int          send_wait = 0;
  int          recv_wait = 0;
  bit          sender_rush = 1'b0;
  bit          receiver_rush = 1'b0;

  barometer_compensation DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  function automatic void note_mismatch(string what, longint want_v, longint got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected %0d, got %0d", what, want_v, got_v);
  endfunction

  // Compensated temperature and pressure for one pair of raw conversions.
  function automatic bc_result_t predict_reading(input logic [23:0] d1, input logic [23:0] d2);
    longint dt, temp, off, sens, dev, low_dev, t2, off2, sens2, press, tc, pc, tw, pw;
    bc_result_t r;
    dt   = longint'(d2) - longint'(cal_words[REG_REF_TEMP]) * 256;
    temp = REF_HUNDREDTHS + ((dt * longint'(cal_words[REG_SLOPE])) >>> 23);
    off  = longint'(cal_words[REG_OFF]) * 131072
           + ((longint'(cal_words[REG_OFF_TEMP]) * dt) >>> 6);
    sens = longint'(cal_words[REG_SENS]) * 65536
           + ((longint'(cal_words[REG_SENS_TEMP]) * dt) >>> 7);
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    // Both cold corrections are decided on the first-order temperature.
    if (temp < REF_HUNDREDTHS) begin
      dev   = temp - REF_HUNDREDTHS;
      t2    = (dt * dt) >>> 31;
      off2  = (61 * dev * dev) >>> 4;
      sens2 = 2 * dev * dev;
      if (temp < LOW_HUNDREDTHS) begin
        low_dev = temp - LOW_HUNDREDTHS;
        off2  += 15 * low_dev * low_dev;
        sens2 += 8 * low_dev * low_dev;
      end
    end
    temp -= t2;
    off  -= off2;
    sens -= sens2;
    press = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
    tc = (temp < TEMP_FLOOR) ? TEMP_FLOOR : (temp > TEMP_CEIL) ? TEMP_CEIL : temp;
    pc = (press < PRESS_FLOOR) ? PRESS_FLOOR : (press > PRESS_CEIL) ? PRESS_CEIL : press;
    tw = tc / 100;
    pw = pc / 100;
    r.temp_hundredths  = tc[14:0];
    r.press_hundredths = pc[16:0];
    r.temp_whole       = tw[7:0];
    r.press_whole      = pw[10:0];
    return r;
  endfunction

  // Sender: one beat at a time from the pending queue, random gap after each.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait = 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_readings.push_back(predict_reading(s_tdata[23:0], s_tdata[47:24]));
      if (!s_tvalid || s_tready) begin
        if (send_wait > 0 || pending_samples.size() == 0) begin
          if (send_wait > 0)
            send_wait--;
          s_tvalid <= 1'b0;
        end else begin
          s_tdata  <= pending_samples.pop_front();
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 24) == 0)
            sender_rush = !sender_rush;
          send_wait = sender_rush ? 0 : $urandom_range(0, 19);
        end
      end
    end
  end

  // Receiver: compares each output beat, then stalls for a random while.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_reading = m_tdata[50:0];
        if (expected_readings.size() == 0) begin
          note_mismatch("result with nothing pending", 0, longint'(m_tdata));
        end else begin
          want_reading = expected_readings.pop_front();
          if (got_reading.temp_hundredths != want_reading.temp_hundredths)
            note_mismatch("temp_hundredths", want_reading.temp_hundredths,
                          got_reading.temp_hundredths);
          if (got_reading.press_hundredths != want_reading.press_hundredths)
            note_mismatch("press_hundredths", want_reading.press_hundredths,
                          got_reading.press_hundredths);
          if (got_reading.temp_whole != want_reading.temp_whole)
            note_mismatch("temp_whole", want_reading.temp_whole, got_reading.temp_whole);
          if (got_reading.press_whole != want_reading.press_whole)
            note_mismatch("press_whole", want_reading.press_whole, got_reading.press_whole);
          if (m_tdata[55:51] != '0)
            note_mismatch("tdata padding", 0, m_tdata[55:51]);
        end
        if ($urandom_range(0, 24) == 0)
          receiver_rush = !receiver_rush;
        recv_wait = receiver_rush ? 0 : $urandom_range(0, 19);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    // Upper bits are junk; the register keeps only the low half.
    pwdata  <= {16'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx <= REG_SLOPE)
      cal_words[idx] = val;
  endtask

  task automatic cfg_check(input logic [2:0] idx);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata != {16'd0, cal_words[idx]})
      note_mismatch("register readback", cal_words[idx], prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic calibrate(input logic [15:0] c1, input logic [15:0] c2,
                           input logic [15:0] c3, input logic [15:0] c4,
                           input logic [15:0] c5, input logic [15:0] c6);
    cfg_write(REG_SENS, c1);
    cfg_write(REG_OFF, c2);
    cfg_write(REG_SENS_TEMP, c3);
    cfg_write(REG_OFF_TEMP, c4);
    cfg_write(REG_REF_TEMP, c5);
    cfg_write(REG_SLOPE, c6);
    cfg_check(REG_SENS);
    cfg_check(REG_OFF);
    cfg_check(REG_SENS_TEMP);
    cfg_check(REG_OFF_TEMP);
    cfg_check(REG_REF_TEMP);
    cfg_check(REG_SLOPE);
  endtask

  // Checked at the falling edge so that every beat handed to the bus counts.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || s_tvalid || expected_readings.size() != 0);
  endtask

  task automatic push_sample(input logic [23:0] d1, input logic [23:0] d2);
    pending_samples.push_back({d2, d1});
  endtask

  // Mostly temperatures near the calibrated reference, where the cold
  // corrections and the saturation edges live; the rest spans the full range.
  task automatic push_random_sample();
    logic [23:0] d1, d2;
    longint      center;
    d1 = 24'($urandom());
    case ($urandom_range(0, 15))
      0: d1 = '0;
      1: d1 = '1;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      d2 = 24'($urandom());
    end else begin
      center = longint'(cal_words[REG_REF_TEMP]) * 256
               + longint'($urandom_range(0, 4194304)) - 2097152;
      if (center < 0)
        center = 0;
      if (center > 16777215)
        center = 16777215;
      d2 = center[23:0];
    end
    push_sample(d1, d2);
  endtask

  initial begin
    for (int i = 0; i <= REG_SLOPE; i++)
      cal_words[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Calibration still at its reset value.
    push_sample(24'd0, 24'd0);
    push_sample(24'hFFFFFF, 24'hFFFFFF);
    push_sample(24'd6465444, 24'd8077636);
    wait_drained();

    calibrate(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    cfg_write(REG_SPARE_LO, 16'($urandom()));
    cfg_write(REG_SPARE_HI, 16'($urandom()));
    cfg_check(REG_SENS);
    // Around the 20.00 C knee, the -15.00 C knee and both saturation limits.
    push_sample(24'd6465444, 24'd8077636);
    push_sample(24'd6465444, 24'd8566784);
    push_sample(24'd6465444, 24'd8566783);
    push_sample(24'd6465444, 24'd8566785);
    push_sample(24'd6465444, 24'd7529784);
    push_sample(24'd6465444, 24'd7529500);
    push_sample(24'd6465444, 24'd7530100);
    push_sample(24'd6465444, 24'd7000000);
    push_sample(24'd6465444, 24'd10492684);
    push_sample(24'd6465444, 24'd12000000);
    push_sample(24'd0, 24'd8077636);
    push_sample(24'hFFFFFF, 24'd8077636);
    push_sample(24'd0, 24'd0);
    push_sample(24'hFFFFFF, 24'hFFFFFF);
    push_sample(24'd0, 24'hFFFFFF);
    push_sample(24'hFFFFFF, 24'd0);
    push_sample(24'h800000, 24'h800000);
    push_sample(24'h7FFFFF, 24'h7FFFFF);
    push_sample(24'd9000000, 24'd6000000);
    push_sample(24'd3000000, 24'd9500000);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: calibrate('1, '1, '1, '1, '1, '1);
        1: calibrate('0, '0, '0, '0, '0, '0);
        2: calibrate('1, '0, '1, '0, '1, '0);
        3: calibrate('0, '1, '0, '1, '0, '1);
        4: calibrate(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        default: calibrate(16'($urandom()), 16'($urandom()), 16'($urandom()),
                           16'($urandom()), 16'($urandom()), 16'($urandom()));
      endcase
      for (int n = 0; n < 100; n++) begin
        push_random_sample();
        // Now and then let the pipeline run dry before feeding more.
        if ($urandom_range(0, 149) == 0)
          wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0)
      $display("barometer_compensation: match");
    else
      $display("barometer_compensation: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("barometer_compensation: mismatch");
    $finish;
  end

endmodule
